FILE: hw/rtl/hre_pkg.sv
// Shared types and fixed-point constants for the Hindmarsh-Rose Euler step core.
`default_nettype none
package hre_pkg;

  localparam int FRAC_BITS = 26;

  localparam longint ONE_Q   = 64'sd1 <<< FRAC_BITS;
  localparam longint C_1P6   = ((64'sd16 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
  localparam longint C_1P92  = ((64'sd192 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam longint C_1P66  = ((64'sd166 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam longint C_0P44  = ((64'sd44 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam longint C_0P241 = ((64'sd241 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint SIG_RANGE = 64'sd8 <<< FRAC_BITS;
  localparam logic [63:0] PROD_LIM = 64'd1 << 58;

  localparam longint RST_STEP  = ((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint RST_DRIVE = ((64'sd325 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
  localparam longint RST_GAIN  = 64'sd4 <<< FRAC_BITS;
  localparam longint RST_RATE  = ((64'sd2 <<< FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint RST_INITX = -(((64'sd16 <<< FRAC_BITS) + 64'sd5) / 64'sd10);

  localparam logic [2:0] REG_SYN_EN = 3'd0;
  localparam logic [2:0] REG_STEP   = 3'd1;
  localparam logic [2:0] REG_DRIVE  = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_RATE   = 3'd4;
  localparam logic [2:0] REG_INITX  = 3'd5;
  localparam logic [2:0] REG_START  = 3'd6;

  localparam logic [1:0] MUL_QF    = 2'd0;
  localparam logic [1:0] MUL_Q30   = 2'd1;
  localparam logic [1:0] MUL_RAW   = 2'd2;
  localparam logic [1:0] MUL_RAW16 = 2'd3;

  typedef struct packed {
    logic               func;
    logic signed [31:0] presyn_voltage;
    logic               presyn_valid;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] membrane_x;
    logic signed [31:0] recovery_y;
    logic signed [31:0] adaptation_z;
    logic signed [63:0] elapsed_time;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [32:0] b;
    logic [1:0]         op;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] p;
    logic               sat;
  } mul_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hre_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
`default_nettype none
interface hre_stream_if #(parameter type PAYLOAD_T = logic) ();
  logic     valid;
  logic     ready;
  PAYLOAD_T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hre_mul.sv
// Shared multi-cycle signed multiplier with rounding, shift and saturation.
`default_nettype none
module hre_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  hre_pkg::mul_req_t req,
  output hre_pkg::mul_rsp_t rsp
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] a_mag_r;
  logic [31:0] b_mag_r;
  logic        neg_r;
  logic [1:0]  op_r;
  logic [95:0] acc_r;
  logic [63:0] p_r;
  logic        sat_r;
  logic        done_r;

  logic [63:0] a_mag;
  logic [32:0] b_mag;
  logic [63:0] pp_lo, pp_hi;
  logic [95:0] rnd_sum, shifted;
  logic        use_rnd, clip;
  logic [63:0] mag, p_fin;

  assign a_mag = req.a[63] ? 64'(-req.a) : 64'(req.a);
  assign b_mag = req.b[32] ? 33'(-req.b) : 33'(req.b);
  assign pp_lo = 64'(a_mag_r[31:0]) * 64'(b_mag_r);
  assign pp_hi = 64'(a_mag_r[63:32]) * 64'(b_mag_r);

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      PH_IDLE: if (req.start) ph_nxt = PH_LO;
      PH_LO:   ph_nxt = PH_HI;
      PH_HI:   ph_nxt = PH_FIN;
      PH_FIN:  ph_nxt = PH_IDLE;
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    rnd_sum = '0;
    shifted = acc_r;
    use_rnd = 1'b0;
    unique case (op_r)
      hre_pkg::MUL_QF: begin
        rnd_sum = acc_r + (96'd1 << (hre_pkg::FRAC_BITS - 1));
        shifted = rnd_sum >> hre_pkg::FRAC_BITS;
        use_rnd = 1'b1;
      end
      hre_pkg::MUL_Q30: begin
        rnd_sum = acc_r + (96'd1 << 29);
        shifted = rnd_sum >> 30;
        use_rnd = 1'b1;
      end
      hre_pkg::MUL_RAW:   shifted = acc_r;
      hre_pkg::MUL_RAW16: shifted = acc_r >> 16;
      default:            shifted = acc_r;
    endcase
    clip  = use_rnd && (shifted > 96'(hre_pkg::PROD_LIM));
    mag   = clip ? hre_pkg::PROD_LIM : shifted[63:0];
    p_fin = neg_r ? (64'd0 - mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == PH_FIN);
    end
    if (ph_r == PH_IDLE && req.start) begin
      a_mag_r <= a_mag;
      b_mag_r <= b_mag[31:0];
      neg_r   <= req.a[63] ^ req.b[32];
      op_r    <= req.op;
    end
    if (ph_r == PH_LO) acc_r <= {32'd0, pp_lo};
    if (ph_r == PH_HI) acc_r <= acc_r + {pp_hi, 32'd0};
    if (ph_r == PH_FIN) begin
      p_r   <= p_fin;
      sat_r <= clip;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = signed'(p_r);
  assign rsp.sat  = sat_r;

endmodule
`default_nettype wire

FILE: hw/rtl/hindmarsh_rose_euler_step_core.sv
// Top level: Hindmarsh-Rose neuron state, sequencer and sigmoid table.
// Usage:
//   in_ch takes one beat per step: func 0 advances the neuron one Euler step
//   (adding the synaptic current when enabled and presyn_valid is set),
//   func 1 reloads the state from initial_x and start_time.
//   out_ch returns one beat per input beat with the new x, y, z, time and
//   a saturation flag. cfg_ch writes registers 0..6 at any time it is idle;
//   it is always ready, and higher indexes are ignored.
//   All products go through one shared multiplier that works through each
//   product in steps (two 32x32 partial products, round and issue).
//   The block takes one item at a time: in_ch is ready only while the
//   sequencer is idle, so a new item waits until the last result is registered.
//   The result sits in an output register; the next item is accepted while
//   it waits, and the sequencer holds at its last step if the receiver
//   still stalls then.
//   Reset (rst_n low, synchronous) restores x=0, y=1, z=0, time=0 and the
//   register defaults; the sigmoid table is a constant and needs no fill.
`default_nettype none
module hindmarsh_rose_euler_step_core #(
  parameter int SIGMOID_ENTRIES = 256
) (
  input logic        clk,
  input logic        rst_n,
  hre_stream_if.sink   in_ch,
  hre_stream_if.source out_ch,
  hre_stream_if.sink   cfg_ch
);

  localparam int IW = $clog2(SIGMOID_ENTRIES + 1);
  localparam int FB = hre_pkg::FRAC_BITS;

  typedef logic [31:0] sig_tab_t [SIGMOID_ENTRIES + 1];

  function automatic longint unsigned cdiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, rm;
    q = '0;
    rm = '0;
    for (int k = 63; k >= 0; k--) begin
      rm = {rm[62:0], n[k]};
      if (rm >= d) begin
        rm = rm - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t tab;
    longint num, term, sum, r;
    longint unsigned an, e, den, nv, prod;
    for (int i = 0; i <= SIGMOID_ENTRIES; i++) begin
      num = 64'sd16 * longint'(i) - 64'sd8 * longint'(SIGMOID_ENTRIES);
      an = (num < 0) ? longint'(-num) : num;
      r = longint'(cdiv(an << 27, 64'(SIGMOID_ENTRIES)));
      term = 64'sd1 <<< 31;
      sum = term;
      for (int k = 1; k <= 12; k++) begin
        prod = longint'(term) * longint'(r);
        term = longint'(cdiv(prod >> 31, 64'(k)));
        sum = ((k & 1) == 1) ? sum - term : sum + term;
      end
      e = (sum < 0) ? 64'd0 : sum;
      for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 30)) >> 31;
      den = (64'd1 << 31) + e;
      nv = (num >= 0) ? (e << 30) : (64'd1 << 61);
      tab[i] = 32'(cdiv(nv + (den >> 1), den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sh8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_LUT   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [3:0] OP_X2  = 4'd0;
  localparam logic [3:0] OP_X3  = 4'd1;
  localparam logic [3:0] OP_T   = 4'd2;
  localparam logic [3:0] OP_DZ  = 4'd3;
  localparam logic [3:0] OP_U   = 4'd4;
  localparam logic [3:0] OP_POS = 4'd5;
  localparam logic [3:0] OP_INT = 4'd6;
  localparam logic [3:0] OP_G   = 4'd7;
  localparam logic [3:0] OP_IS  = 4'd8;
  localparam logic [3:0] OP_MX  = 4'd9;
  localparam logic [3:0] OP_MY  = 4'd10;
  localparam logic [3:0] OP_MZ  = 4'd11;
  localparam logic [3:0] OP_R2  = 4'd12;
  localparam logic [3:0] OP_RZ  = 4'd13;

  // configuration
  logic               syn_en_r;
  logic [30:0]        step_r;
  logic signed [31:0] drive_r, gain_r, rate_r, initx_r, start_r;

  // neuron state
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [63:0] time_r;

  // sequencer
  logic [2:0] state_r, state_nxt;
  logic [3:0] op_r;
  logic       func_r, syn_r, flag_r;
  logic signed [31:0] v_r;

  // intermediates
  logic signed [63:0] x2_r, x3_r, t_r, dz_r, u_r, pos_r, g_r, isyn_r;
  logic signed [63:0] dx_r, dy_r, mx_r, my_r, mz_r;
  logic [31:0] tab_a_r, tab_b_r;
  logic [30:0] s_r;

  hre_pkg::out_beat_t out_r;
  logic               out_valid_r;

  hre_pkg::mul_req_t mul_req;
  hre_pkg::mul_rsp_t mul_rsp;

  logic signed [63:0] x_ext, y_ext, z_ext, x0_ext, u_cl;
  logic [IW-1:0]      lut_idx, lut_idx_b;
  logic [31:0]        tab_diff;
  logic               out_free, in_acc;
  logic [32:0]        fin_x, fin_y, fin_z;
  logic signed [63:0] fin_time;
  logic               fin_tclip;
  logic signed [64:0] tsum;

  hre_mul u_mul (
    .clk (clk),
    .rst_n (rst_n),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign x_ext  = 64'(x_r);
  assign y_ext  = 64'(y_r);
  assign z_ext  = 64'(z_r);
  assign x0_ext = 64'(initx_r);

  assign u_cl = (u_r > hre_pkg::SIG_RANGE) ? hre_pkg::SIG_RANGE :
                (u_r < -hre_pkg::SIG_RANGE) ? -hre_pkg::SIG_RANGE : u_r;
  assign lut_idx   = pos_r[FB+4 +: IW];
  assign lut_idx_b = (lut_idx >= IW'(SIGMOID_ENTRIES)) ? IW'(SIGMOID_ENTRIES)
                                                       : lut_idx + IW'(1);
  assign tab_diff  = (tab_a_r >= tab_b_r) ? tab_a_r - tab_b_r : tab_b_r - tab_a_r;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    mul_req.start = (state_r == ST_ISSUE);
    mul_req.op    = hre_pkg::MUL_QF;
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (op_r)
      OP_X2: begin
        mul_req.a = x_ext;
        mul_req.b = 33'(x_r);
      end
      OP_X3: begin
        mul_req.a = x2_r;
        mul_req.b = 33'(x_r);
      end
      OP_T: begin
        mul_req.a = x_ext + hre_pkg::C_1P6;
        mul_req.b = 33'(gain_r);
      end
      OP_DZ: begin
        mul_req.a = t_r - z_ext;
        mul_req.b = 33'(rate_r);
      end
      OP_U: begin
        mul_req.a = -hre_pkg::C_1P66 - 64'(v_r);
        mul_req.b = 33'(hre_pkg::C_0P44);
      end
      OP_POS: begin
        mul_req.a  = u_cl + hre_pkg::SIG_RANGE;
        mul_req.b  = 33'(SIGMOID_ENTRIES);
        mul_req.op = hre_pkg::MUL_RAW;
      end
      OP_INT: begin
        mul_req.a  = {32'd0, tab_diff};
        mul_req.b  = {17'd0, pos_r[FB+3 -: 16]};
        mul_req.op = hre_pkg::MUL_RAW16;
      end
      OP_G: begin
        mul_req.a = x_ext + hre_pkg::C_1P92;
        mul_req.b = 33'(hre_pkg::C_0P241);
      end
      OP_IS: begin
        mul_req.a  = g_r;
        mul_req.b  = {2'd0, s_r};
        mul_req.op = hre_pkg::MUL_Q30;
      end
      OP_MX: begin
        mul_req.a = dx_r;
        mul_req.b = {2'd0, step_r};
      end
      OP_MY: begin
        mul_req.a = dy_r;
        mul_req.b = {2'd0, step_r};
      end
      OP_MZ: begin
        mul_req.a = dz_r;
        mul_req.b = {2'd0, step_r};
      end
      OP_R2: begin
        mul_req.a = x0_ext;
        mul_req.b = 33'(initx_r);
      end
      OP_RZ: begin
        mul_req.a = x0_ext + hre_pkg::C_1P6;
        mul_req.b = 33'(gain_r);
      end
      default: mul_req.a = '0;
    endcase
  end

  always_comb begin
    tsum      = 65'(time_r) + 65'(step_r);
    fin_tclip = 1'b0;
    if (func_r) begin
      fin_x    = {1'b0, initx_r};
      fin_y    = sat32(hre_pkg::ONE_Q - ((x2_r <<< 2) + x2_r));
      fin_z    = sat32(t_r);
      fin_time = 64'(start_r);
    end else begin
      fin_x = sat32(x_ext + mx_r);
      fin_y = sat32(y_ext + my_r);
      fin_z = sat32(z_ext + mz_r);
      if (!tsum[64] && tsum[63]) begin
        fin_tclip = 1'b1;
        fin_time  = 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
        fin_time = tsum[63:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (mul_rsp.done) begin
          unique case (op_r)
            OP_DZ:  state_nxt = syn_r ? ST_ISSUE : ST_SUM;
            OP_POS: state_nxt = ST_LUT;
            OP_IS:  state_nxt = ST_SUM;
            OP_MZ:  state_nxt = ST_FIN;
            OP_RZ:  state_nxt = ST_FIN;
            default: state_nxt = ST_ISSUE;
          endcase
        end
      end
      ST_LUT:  state_nxt = ST_ISSUE;
      ST_SUM:  state_nxt = ST_ISSUE;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      syn_en_r    <= 1'b0;
      step_r      <= 31'(hre_pkg::RST_STEP);
      drive_r     <= 32'(hre_pkg::RST_DRIVE);
      gain_r      <= 32'(hre_pkg::RST_GAIN);
      rate_r      <= 32'(hre_pkg::RST_RATE);
      initx_r     <= 32'(hre_pkg::RST_INITX);
      start_r     <= '0;
      x_r         <= '0;
      y_r         <= 32'(hre_pkg::ONE_Q);
      z_r         <= '0;
      time_r      <= '0;
      op_r        <= OP_X2;
      flag_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.index)
          hre_pkg::REG_SYN_EN: syn_en_r <= cfg_ch.data.value[0];
          hre_pkg::REG_STEP:   step_r   <= cfg_ch.data.value[30:0];
          hre_pkg::REG_DRIVE:  drive_r  <= cfg_ch.data.value;
          hre_pkg::REG_GAIN:   gain_r   <= cfg_ch.data.value;
          hre_pkg::REG_RATE:   rate_r   <= cfg_ch.data.value;
          hre_pkg::REG_INITX:  initx_r  <= cfg_ch.data.value;
          hre_pkg::REG_START:  start_r  <= cfg_ch.data.value;
          default: ;
        endcase
      end

      if (in_acc) begin
        func_r <= in_ch.data.func;
        v_r    <= in_ch.data.presyn_voltage;
        syn_r  <= syn_en_r && in_ch.data.presyn_valid;
        flag_r <= 1'b0;
        op_r   <= in_ch.data.func ? OP_R2 : OP_X2;
      end

      if (state_r == ST_WAIT && mul_rsp.done) begin
        if (mul_rsp.sat) flag_r <= 1'b1;
        unique case (op_r)
          OP_X2: begin
            x2_r <= mul_rsp.p;
            op_r <= OP_X3;
          end
          OP_X3: begin
            x3_r <= mul_rsp.p;
            op_r <= OP_T;
          end
          OP_T: begin
            t_r  <= mul_rsp.p;
            op_r <= OP_DZ;
          end
          OP_DZ: begin
            dz_r <= mul_rsp.p;
            if (!syn_r) isyn_r <= '0;
            op_r <= syn_r ? OP_U : OP_MX;
          end
          OP_U: begin
            u_r  <= mul_rsp.p;
            op_r <= OP_POS;
          end
          OP_POS: begin
            pos_r <= mul_rsp.p;
            op_r  <= OP_INT;
          end
          OP_INT: begin
            s_r  <= (tab_a_r >= tab_b_r) ? 31'(tab_a_r - mul_rsp.p[31:0])
                                         : 31'(tab_a_r + mul_rsp.p[31:0]);
            op_r <= OP_G;
          end
          OP_G: begin
            g_r  <= mul_rsp.p;
            op_r <= OP_IS;
          end
          OP_IS: begin
            isyn_r <= mul_rsp.p;
            op_r   <= OP_MX;
          end
          OP_MX: begin
            mx_r <= mul_rsp.p;
            op_r <= OP_MY;
          end
          OP_MY: begin
            my_r <= mul_rsp.p;
            op_r <= OP_MZ;
          end
          OP_MZ: mz_r <= mul_rsp.p;
          OP_R2: begin
            x2_r <= mul_rsp.p;
            op_r <= OP_RZ;
          end
          OP_RZ: t_r <= mul_rsp.p;
          default: ;
        endcase
      end

      if (state_r == ST_LUT) begin
        tab_a_r <= SIG_TAB[lut_idx];
        tab_b_r <= SIG_TAB[lut_idx_b];
      end

      if (state_r == ST_SUM) begin
        dx_r <= y_ext + (x2_r <<< 1) + x2_r - x3_r - z_ext + 64'(drive_r) + isyn_r;
        dy_r <= hre_pkg::ONE_Q - (x2_r <<< 2) - x2_r - y_ext;
      end

      if (state_r == ST_FIN && out_free) begin
        x_r                <= fin_x[31:0];
        y_r                <= fin_y[31:0];
        z_r                <= fin_z[31:0];
        time_r             <= fin_time;
        out_r.membrane_x   <= fin_x[31:0];
        out_r.recovery_y   <= fin_y[31:0];
        out_r.adaptation_z <= fin_z[31:0];
        out_r.elapsed_time <= fin_time;
        out_r.saturated    <= flag_r | fin_x[32] | fin_y[32] | fin_z[32] | fin_tclip;
        out_valid_r        <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/hre_chk.sv
// Port-level checker for the Hindmarsh-Rose Euler step core, with its bind.
`default_nettype none
module hre_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input hre_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready while an item is in flight");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hindmarsh_rose_euler_step_core hre_chk u_hre_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

FILE: bench/tb_hindmarsh_rose_euler_step_core.sv
// Self-checking testbench for the Hindmarsh-Rose Euler step core.
`timescale 1ns / 100ps
module tb_hindmarsh_rose_euler_step_core;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;

  hre_stream_if #(.PAYLOAD_T(hre_pkg::in_beat_t))  in_ch ();
  hre_stream_if #(.PAYLOAD_T(hre_pkg::out_beat_t)) out_ch ();
  hre_stream_if #(.PAYLOAD_T(hre_pkg::cfg_beat_t)) cfg_ch ();

  hindmarsh_rose_euler_step_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // neuron state and register copy
  logic               nr_syn;
  logic [30:0]        nr_step;
  logic signed [31:0] nr_drive, nr_gain, nr_rate, nr_initx, nr_start;
  logic signed [31:0] nr_x, nr_y, nr_z;
  longint             nr_time;
  logic               nr_clip;
  logic [31:0]        sig_tab [0:256];

  hre_pkg::out_beat_t expected_beats [$];
  int errors, cycles, n_steps, n_reinit, n_syn, n_sat;
  int burst_left, stall_left;
  bit idle_on, stall_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_hindmarsh_rose_euler_step_core: FAIL");
      $finish;
    end
  end

  function automatic longint fx_mul(longint a, longint b, int s);
    logic         neg = (a < 0) != (b < 0);
    logic [63:0]  ua  = (a < 0) ? -a : a;
    logic [63:0]  ub  = (b < 0) ? -b : b;
    logic [127:0] p;
    p = {64'd0, ua} * {64'd0, ub};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    if (p[127:64] != 0 || p[63:0] > hre_pkg::PROD_LIM) begin
      nr_clip = 1'b1;
      p = {64'd0, hre_pkg::PROD_LIM};
    end
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      nr_clip = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      nr_clip = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] sig_point(int i);
    longint num = 16 * i - 2048;
    longint unsigned an, ru, tu, e, den, nv;
    longint term, sum;
    an = (num < 0) ? -num : num;
    ru = (an << 27) / 256;
    term = 64'sd1 <<< 31;
    sum = term;
    for (int k = 1; k <= 12; k++) begin
      tu = term;
      tu = (tu * ru) >> 31;
      term = $signed(tu) / k;
      sum += (k & 1) ? -term : term;
    end
    e = (sum < 0) ? 0 : sum;
    for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 30)) >> 31;
    den = (64'd1 << 31) + e;
    nv = (num >= 0) ? (e << 30) : (64'd1 << 61);
    return 32'((nv + den / 2) / den);
  endfunction

  function automatic longint sig_interp(longint u);
    longint unsigned span = 64'd16 << hre_pkg::FRAC_BITS;
    longint unsigned pos, idx, f16, a, b;
    if (u > hre_pkg::SIG_RANGE) u = hre_pkg::SIG_RANGE;
    if (u < -hre_pkg::SIG_RANGE) u = -hre_pkg::SIG_RANGE;
    pos = (u + hre_pkg::SIG_RANGE) * 256;
    idx = pos / span;
    if (idx >= 256) return sig_tab[256];
    f16 = ((pos % span) << 16) / span;
    a = sig_tab[idx];
    b = sig_tab[idx + 1];
    if (a >= b) return a - (((a - b) * f16) >> 16);
    return a + (((b - a) * f16) >> 16);
  endfunction

  task automatic neuron_reset();
    nr_syn = 1'b0;
    nr_step = 31'(hre_pkg::RST_STEP);
    nr_drive = 32'(hre_pkg::RST_DRIVE);
    nr_gain = 32'(hre_pkg::RST_GAIN);
    nr_rate = 32'(hre_pkg::RST_RATE);
    nr_initx = 32'(hre_pkg::RST_INITX);
    nr_start = 0;
    nr_x = 0;
    nr_y = 32'(hre_pkg::ONE_Q);
    nr_z = 0;
    nr_time = 0;
    for (int i = 0; i <= 256; i++) sig_tab[i] = sig_point(i);
  endtask

  function automatic hre_pkg::out_beat_t neuron_advance(hre_pkg::in_beat_t b);
    hre_pkg::out_beat_t r;
    longint x = nr_x, y = nr_y, z = nr_z, sg = nr_gain;
    longint h = nr_step;
    longint x2, x3, isyn, dx, dy, dz, u, s, g, x0;
    nr_clip = 1'b0;
    if (b.func) begin
      x0 = nr_initx;
      x2 = fx_mul(x0, x0, hre_pkg::FRAC_BITS);
      nr_x = clip32(x0);
      nr_y = clip32(hre_pkg::ONE_Q - 5 * x2);
      nr_z = clip32(fx_mul(sg, x0 + hre_pkg::C_1P6, hre_pkg::FRAC_BITS));
      nr_time = nr_start;
    end else begin
      x2 = fx_mul(x, x, hre_pkg::FRAC_BITS);
      x3 = fx_mul(x2, x, hre_pkg::FRAC_BITS);
      isyn = 0;
      if (nr_syn && b.presyn_valid) begin
        u = fx_mul(hre_pkg::C_0P44, -hre_pkg::C_1P66 - longint'(b.presyn_voltage),
                   hre_pkg::FRAC_BITS);
        s = sig_interp(u);
        g = fx_mul(hre_pkg::C_0P241, x + hre_pkg::C_1P92, hre_pkg::FRAC_BITS);
        isyn = fx_mul(g, s, 30);
      end
      dx = y + 3 * x2 - x3 - z + longint'(nr_drive) + isyn;
      dy = hre_pkg::ONE_Q - 5 * x2 - y;
      dz = fx_mul(nr_rate, fx_mul(sg, x + hre_pkg::C_1P6, hre_pkg::FRAC_BITS) - z,
                  hre_pkg::FRAC_BITS);
      nr_x = clip32(x + fx_mul(h, dx, hre_pkg::FRAC_BITS));
      nr_y = clip32(y + fx_mul(h, dy, hre_pkg::FRAC_BITS));
      nr_z = clip32(z + fx_mul(h, dz, hre_pkg::FRAC_BITS));
      if (nr_time > 64'sh7FFFFFFFFFFFFFFF - h) begin
        nr_clip = 1'b1;
        nr_time = 64'sh7FFFFFFFFFFFFFFF;
      end else begin
        nr_time += h;
      end
    end
    r.membrane_x = nr_x;
    r.recovery_y = nr_y;
    r.adaptation_z = nr_z;
    r.elapsed_time = nr_time;
    r.saturated = nr_clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk) begin
    hre_pkg::out_beat_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", got.membrane_x, 0);
      end else begin
        want = expected_beats.pop_front();
        if (got.saturated) n_sat++;
        if (got.membrane_x !== want.membrane_x)
          report_mismatch("membrane_x", got.membrane_x, want.membrane_x);
        if (got.recovery_y !== want.recovery_y)
          report_mismatch("recovery_y", got.recovery_y, want.recovery_y);
        if (got.adaptation_z !== want.adaptation_z)
          report_mismatch("adaptation_z", got.adaptation_z, want.adaptation_z);
        if (got.elapsed_time !== want.elapsed_time)
          report_mismatch("elapsed_time", got.elapsed_time, want.elapsed_time);
        if (got.saturated !== want.saturated)
          report_mismatch("saturated", got.saturated, want.saturated);
      end
    end
  end

  always @(negedge clk) begin
    if (cycles % 700 == 0) stall_on <= ($urandom_range(0, 2) != 0);
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (stall_on && $urandom_range(0, 4) == 0) stall_left <= $urandom_range(1, 8);
    end
  end

  task automatic send_beat(logic func, logic signed [31:0] v, logic pv);
    hre_pkg::in_beat_t b;
    int gap = 0;
    b.func = func;
    b.presyn_voltage = v;
    b.presyn_valid = pv;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      idle_on = ($urandom_range(0, 3) != 0);
      if (idle_on) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
    expected_beats.push_back(neuron_advance(b));
    if (func) n_reinit++;
    else n_steps++;
    if (!func && nr_syn && pv) n_syn++;
  endtask

  task automatic drain();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    hre_pkg::cfg_beat_t c;
    c.index = idx;
    c.value = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid <= 1'b0;
    case (idx)
      hre_pkg::REG_SYN_EN: nr_syn = val[0];
      hre_pkg::REG_STEP:   nr_step = val[30:0];
      hre_pkg::REG_DRIVE:  nr_drive = val;
      hre_pkg::REG_GAIN:   nr_gain = val;
      hre_pkg::REG_RATE:   nr_rate = val;
      hre_pkg::REG_INITX:  nr_initx = val;
      hre_pkg::REG_START:  nr_start = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_beat(1'b0, 0, 1'b1);
    send_beat(1'b0, 32'sh7FFFFFFF, 1'b0);
    send_beat(1'b1, 0, 1'b0);
    repeat (3) send_beat(1'b0, $urandom, 1'b1);
    drain();
  endtask

  task automatic test_synapse_extremes();
    write_reg(hre_pkg::REG_SYN_EN, 32'd1);
    send_beat(1'b1, 0, 1'b0);
    send_beat(1'b0, 32'sh80000000, 1'b1);
    send_beat(1'b0, 32'sh7FFFFFFF, 1'b1);
    send_beat(1'b0, 0, 1'b1);
    send_beat(1'b0, 32'(-hre_pkg::C_1P66), 1'b1);
    send_beat(1'b0, 32'sh7FFFFFFF, 1'b0);
    send_beat(1'b0, 32'sh04000000, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(hre_pkg::REG_STEP, 32'hFFFFFFFF);
    write_reg(hre_pkg::REG_DRIVE, 32'h7FFFFFFF);
    write_reg(hre_pkg::REG_GAIN, 32'h7FFFFFFF);
    write_reg(hre_pkg::REG_RATE, 32'h7FFFFFFF);
    write_reg(hre_pkg::REG_INITX, 32'h80000000);
    write_reg(hre_pkg::REG_START, 32'h7FFFFFFF);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    send_beat(1'b1, 0, 1'b0);
    repeat (3) send_beat(1'b0, 32'sh80000000, 1'b1);
    drain();
    write_reg(hre_pkg::REG_STEP, 32'd0);
    write_reg(hre_pkg::REG_DRIVE, 32'h80000000);
    write_reg(hre_pkg::REG_GAIN, 32'h80000000);
    write_reg(hre_pkg::REG_RATE, 32'h80000000);
    write_reg(hre_pkg::REG_INITX, 32'h7FFFFFFF);
    write_reg(hre_pkg::REG_START, 32'h80000000);
    send_beat(1'b1, 0, 1'b0);
    repeat (3) send_beat(1'b0, 32'sh7FFFFFFF, 1'b1);
    drain();
  endtask

  function automatic logic [31:0] pick_value(logic [2:0] idx);
    if ($urandom_range(0, 9) == 0) return $urandom;
    case (idx)
      hre_pkg::REG_STEP:  return $urandom_range(1, 1 << 22);
      hre_pkg::REG_DRIVE: return $urandom_range(0, 6 << 26) - (1 << 26);
      hre_pkg::REG_GAIN:  return $urandom_range(0, 8 << 26);
      hre_pkg::REG_RATE:  return $urandom_range(0, 1 << 22);
      hre_pkg::REG_INITX: return $urandom_range(0, 4 << 26) - (2 << 26);
      default:            return $urandom;
    endcase
  endfunction

  task automatic test_random_phases();
    logic signed [31:0] v;
    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r <= 6; r++) write_reg(r[2:0], pick_value(r[2:0]));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      send_beat(1'b1, $urandom, 1'($urandom));
      for (int n = 0; n < 52; n++) begin
        if ($urandom_range(0, 3) != 0) v = $urandom_range(0, 6 << 26) - (3 << 26);
        else v = $urandom;
        send_beat($urandom_range(0, 11) == 0, v, $urandom_range(0, 3) != 0);
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    neuron_reset();
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_defaults();
    test_synapse_extremes();
    test_register_extremes();
    test_random_phases();
    $display("covered %0d Euler steps (%0d with synaptic current) and %0d reinitializations",
             n_steps, n_syn, n_reinit);
    $display("%0d results carried the saturation flag; %0d mismatches", n_sat, errors);
    if (errors == 0) begin
      $display("tb_hindmarsh_rose_euler_step_core: PASS");
    end else begin
      $display("tb_hindmarsh_rose_euler_step_core: FAIL");
    end
    $finish;
  end

endmodule
